@@ sv/scbl_pkg.sv @@
package scbl_pkg;

    // Fixed by the payload structs: one field per channel.
    localparam int CHANNELS        = 6;
    localparam int SAMPLE_WIDTH    = 16;
    localparam int HIST_WIDTH      = SAMPLE_WIDTH + 8;
    localparam int COEF_WIDTH      = 18;
    localparam int CFG_INDEX_WIDTH = 3;

    // Datapath widths inside one lane.
    localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int FF_WIDTH   = PROD_WIDTH + 2;
    localparam int FB_WIDTH   = COEF_WIDTH + HIST_WIDTH;
    localparam int ACC_WIDTH  = FF_WIDTH + 8 + 2;
    localparam int RND_WIDTH  = ACC_WIDTH - 16;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [HIST_WIDTH-1:0]   hist_t;
    typedef logic signed [COEF_WIDTH-1:0]   coef_t;
    typedef logic [CFG_INDEX_WIDTH-1:0]     cfg_index_t;

    typedef sample_t [CHANNELS-1:0] sample_vec_t;
    typedef hist_t   [CHANNELS-1:0] hist_vec_t;

    typedef struct packed {
        sample_t sample_ch5;
        sample_t sample_ch4;
        sample_t sample_ch3;
        sample_t sample_ch2;
        sample_t sample_ch1;
        sample_t sample_ch0;
    } sample_word_t;

    typedef struct packed {
        sample_t filtered_ch5;
        sample_t filtered_ch4;
        sample_t filtered_ch3;
        sample_t filtered_ch2;
        sample_t filtered_ch1;
        sample_t filtered_ch0;
    } filtered_word_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coef_set_t;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } pipe_ctl_t;

    localparam cfg_index_t REG_B0 = 3'd0;
    localparam cfg_index_t REG_B1 = 3'd1;
    localparam cfg_index_t REG_B2 = 3'd2;
    localparam cfg_index_t REG_A1 = 3'd3;
    localparam cfg_index_t REG_A2 = 3'd4;

    // Butterworth set: 0.0201, 0.0402, 0.0201, -1.561, 0.6414 in Q2.16.
    localparam coef_t COEF_B0_RST = 18'sd1317;
    localparam coef_t COEF_B1_RST = 18'sd2634;
    localparam coef_t COEF_B2_RST = 18'sd1317;
    localparam coef_t COEF_A1_RST = -18'sd102302;
    localparam coef_t COEF_A2_RST = 18'sd42035;

    function automatic sample_vec_t unpack_samples(input sample_word_t w);
        sample_vec_t v;
        v[0] = w.sample_ch0;
        v[1] = w.sample_ch1;
        v[2] = w.sample_ch2;
        v[3] = w.sample_ch3;
        v[4] = w.sample_ch4;
        v[5] = w.sample_ch5;
        return v;
    endfunction

    function automatic filtered_word_t pack_filtered(input sample_vec_t v);
        filtered_word_t w;
        w.filtered_ch0 = v[0];
        w.filtered_ch1 = v[1];
        w.filtered_ch2 = v[2];
        w.filtered_ch3 = v[3];
        w.filtered_ch4 = v[4];
        w.filtered_ch5 = v[5];
        return w;
    endfunction

    // Clamp the rounded Q16.8 sum into history width.
    function automatic hist_t sat_hist(input logic signed [RND_WIDTH-1:0] v);
        logic [RND_WIDTH-HIST_WIDTH:0] upper;
        hist_t                         res;
        upper = v[RND_WIDTH-1:HIST_WIDTH-1];
        if ((&upper) || !(|upper))
        begin
            res = v[HIST_WIDTH-1:0];
        end
        else if (v[RND_WIDTH-1])
        begin
            res = {1'b1, {(HIST_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(HIST_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

    // Q16.8 to integer, round half up, saturate to sample width.
    function automatic sample_t round_out(input hist_t y);
        logic [HIST_WIDTH:0]   t;
        logic [SAMPLE_WIDTH:0] q;
        sample_t               res;
        t = {y[HIST_WIDTH-1], y} + (HIST_WIDTH+1)'(128);
        q = t[HIST_WIDTH:8];
        if (q[SAMPLE_WIDTH] == q[SAMPLE_WIDTH-1])
        begin
            res = q[SAMPLE_WIDTH-1:0];
        end
        else if (q[SAMPLE_WIDTH])
        begin
            res = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ sv/scbl_ctrl.sv @@
module scbl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    output logic                filtered_valid,
    input  logic                filtered_ready,
    output scbl_pkg::pipe_ctl_t ctl
);
    import scbl_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;

    // Each stage moves when the one after it is empty or moving.
    always_comb
    begin
        ctl.ld4 = v3_reg && (!v4_reg || filtered_ready);
        ctl.ld3 = v2_reg && (!v3_reg || ctl.ld4);
        ctl.ld2 = v1_reg && (!v2_reg || ctl.ld3);
        sample_ready = !v1_reg || ctl.ld2;
        ctl.ld1 = sample_valid && sample_ready;

        v1_next = ctl.ld1 ? 1'b1 : (ctl.ld2 ? 1'b0 : v1_reg);
        v2_next = ctl.ld2 ? 1'b1 : (ctl.ld3 ? 1'b0 : v2_reg);
        v3_next = ctl.ld3 ? 1'b1 : (ctl.ld4 ? 1'b0 : v3_reg);
        v4_next = ctl.ld4 ? 1'b1 : (filtered_ready ? 1'b0 : v4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign filtered_valid = v4_reg;

endmodule

@@ sv/scbl_lane.sv @@
module scbl_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  scbl_pkg::pipe_ctl_t ctl,
    input  scbl_pkg::coef_set_t coef,
    input  scbl_pkg::sample_t   x,
    output scbl_pkg::hist_t     y
);
    import scbl_pkg::*;

    sample_t                        x1_reg, x2_reg;
    logic signed [PROD_WIDTH-1:0]   prod0_reg, prod1_reg, prod2_reg;
    logic signed [FF_WIDTH-1:0]     ff_reg;
    hist_t                          y1_reg, y2_reg;
    hist_t                          y_next;
    logic signed [FB_WIDTH-1:0]     a2y2_reg;
    logic signed [FB_WIDTH-1:0]     a1y1;
    logic signed [ACC_WIDTH-1:0]    acc;

    // Stage 1: feedforward products, shift input history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
        end
        else if (ctl.ld1)
        begin
            x1_reg <= x;
            x2_reg <= x1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            prod0_reg <= coef.b0 * x;
            prod1_reg <= coef.b1 * x1_reg;
            prod2_reg <= coef.b2 * x2_reg;
        end
        if (ctl.ld2)
        begin
            ff_reg <= FF_WIDTH'(prod0_reg) + FF_WIDTH'(prod1_reg) + FF_WIDTH'(prod2_reg);
        end
    end

    // Stage 3: close the recursion; a2*y2 is prepared ahead in its own register.
    always_comb
    begin
        a1y1   = coef.a1 * y1_reg;
        acc    = (ACC_WIDTH'(ff_reg) <<< 8) - ACC_WIDTH'(a1y1) - ACC_WIDTH'(a2y2_reg)
                 + ACC_WIDTH'(32768);
        y_next = sat_hist(acc[ACC_WIDTH-1:16]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg   <= '0;
            y2_reg   <= '0;
            a2y2_reg <= '0;
        end
        else
        begin
            if (ctl.ld3)
            begin
                y1_reg <= y_next;
                y2_reg <= y1_reg;
            end
            // refresh every cycle so a new a2 is picked up while idle
            a2y2_reg <= coef.a2 * (ctl.ld3 ? y1_reg : y2_reg);
        end
    end

    assign y = y1_reg;

endmodule

@@ sv/scbl_merge.sv @@
module scbl_merge (
    input  logic                     clk,
    input  scbl_pkg::pipe_ctl_t      ctl,
    input  scbl_pkg::hist_vec_t      y_vec,
    output scbl_pkg::filtered_word_t filtered
);
    import scbl_pkg::*;

    sample_vec_t    rounded;
    filtered_word_t out_reg;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            rounded[c] = round_out(y_vec[c]);
        end
    end

    // Gather the lanes into one output word.
    always_ff @(posedge clk)
    begin
        if (ctl.ld4)
        begin
            out_reg <= pack_filtered(rounded);
        end
    end

    assign filtered = out_reg;

endmodule

@@ sv/six_channel_biquad_lowpass.sv @@
// Six-channel second-order low-pass (direct form I biquad), one lane per channel
// with shared Q2.16 coefficients b0, b1, b2, a1, a2 written through the config
// port (index 0 to 4, others ignored; reset gives a Butterworth set). While the
// output side is ready it takes one sample word per clock and returns one filtered
// word per clock; a word passes the product, feedforward-sum, recursion and output
// registers, and filtered_valid rises once it is in the output word. The rate of
// one word per clock is set by the recurrence stage, where a1*y1 plus the sum and
// saturation close the per-channel feedback loop combinationally into y1. History
// is kept in Q16.8 and cleared at reset; outputs are rounded half up and saturated
// to 16 bits. Write coefficients only while no word is in flight.
module six_channel_biquad_lowpass (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_ready,
    input  scbl_pkg::sample_word_t   sample,
    output logic                     filtered_valid,
    input  logic                     filtered_ready,
    output scbl_pkg::filtered_word_t filtered,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  scbl_pkg::cfg_index_t     cfg_index,
    input  scbl_pkg::coef_t          cfg_data
);
    import scbl_pkg::*;

    coef_set_t   coef_reg;
    pipe_ctl_t   ctl;
    sample_vec_t x_vec;
    hist_vec_t   y_vec;

    // Coefficient writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= COEF_B0_RST;
            coef_reg.b1 <= COEF_B1_RST;
            coef_reg.b2 <= COEF_B2_RST;
            coef_reg.a1 <= COEF_A1_RST;
            coef_reg.a2 <= COEF_A2_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_B0:  coef_reg.b0 <= cfg_data;
                REG_B1:  coef_reg.b1 <= cfg_data;
                REG_B2:  coef_reg.b2 <= cfg_data;
                REG_A1:  coef_reg.a1 <= cfg_data;
                REG_A2:  coef_reg.a2 <= cfg_data;
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    // Handshake and stage enables shared by all lanes.
    scbl_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .filtered_valid (filtered_valid),
        .filtered_ready (filtered_ready),
        .ctl            (ctl)
    );

    assign x_vec = unpack_samples(sample);

    // One filter lane per channel, each with its own history.
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        scbl_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .coef  (coef_reg),
            .x     (x_vec[c]),
            .y     (y_vec[c])
        );
    end

    // Round, saturate and hold the output word until it is taken.
    scbl_merge u_merge (
        .clk      (clk),
        .ctl      (ctl),
        .y_vec    (y_vec),
        .filtered (filtered)
    );

endmodule

@@ sv/scbl_checker.sv @@
module scbl_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     sample_valid,
    input logic                     sample_ready,
    input logic                     filtered_valid,
    input logic                     filtered_ready,
    input scbl_pkg::filtered_word_t filtered
);
    import scbl_pkg::*;

    localparam int DEPTH = 4;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    // Track words accepted but not yet delivered.
    always_comb
    begin
        pending_next = pending_reg;
        if (sample_valid && sample_ready)
        begin
            pending_next = pending_next + 3'd1;
        end
        if (filtered_valid && filtered_ready)
        begin
            pending_next = pending_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        filtered_valid && !filtered_ready |=> filtered_valid && $stable(filtered))
        else $error("output word changed while stalled");

    a_full_rate: assert property (@(posedge clk) disable iff (!rst_n)
        filtered_ready |-> sample_ready)
        else $error("input stalled while output side is ready");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        filtered_valid |-> pending_reg != 3'd0)
        else $error("output word with no word in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(DEPTH))
        else $error("more words in flight than pipeline stages");

endmodule

bind six_channel_biquad_lowpass scbl_checker u_checker (.*);
